// ===== rtl/core/pidpwm_pkg.sv =====
// pidpwm_pkg: widths, codes, microcode table and saturation helpers for the
// pid controller with filtered derivative. Used by every module of the block.
// No dependencies.
package pidpwm_pkg;

   // word and fixed point geometry
   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int MUL_W     = DATA_W + 1;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int PWM_W     = PROD_W - FRAC_BITS;
   localparam int CLIP_W    = 2;
   localparam int REQ_W     = 2 * DATA_W;
   localparam int RSP_W     = ((DATA_W + CLIP_W + 7) / 8) * 8;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W    = 4;

   // register reset values
   localparam logic signed [DATA_W-1:0] RST_PROP_GAIN  = 32'sd0;
   localparam logic signed [DATA_W-1:0] RST_SP_WEIGHT  = 32'sd65536;
   localparam logic signed [DATA_W-1:0] RST_INTEG_GAIN = 32'sd0;
   localparam logic signed [DATA_W-1:0] RST_D_POLE     = 32'sd0;
   localparam logic signed [DATA_W-1:0] RST_D_GAIN     = 32'sd0;
   localparam logic signed [DATA_W-1:0] RST_PWM_MAX    = 32'sd131072000;
   localparam logic signed [DATA_W-1:0] RST_PWM_MIN    = 32'sd65536000;
   localparam logic signed [DATA_W-1:0] RST_PWM_CENTER = 32'sd98304000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN  = 3'd0,
      REG_SP_WEIGHT  = 3'd1,
      REG_INTEG_GAIN = 3'd2,
      REG_D_POLE     = 3'd3,
      REG_D_GAIN     = 3'd4,
      REG_PWM_MAX    = 3'd5,
      REG_PWM_MIN    = 3'd6,
      REG_PWM_CENTER = 3'd7
   } csr_idx_type;

   typedef enum logic [CLIP_W-1:0] {
      CLIP_NONE = 2'd0,
      CLIP_MIN  = 2'd1,
      CLIP_MAX  = 2'd2
   } clip_type;

   // multiplier operand selects
   typedef enum logic [2:0] {
      MA_NONE, MA_WEIGHT, MA_KP, MA_KI, MA_POLE, MA_GAIN, MA_SPAN
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_TARGET, MB_WT, MB_ERR, MB_DACC, MB_DY, MB_U
   } mul_b_type;

   // datapath operations, each with fixed sources and destination
   typedef enum logic [3:0] {
      OP_NOP, OP_LOAD, OP_DIFF, OP_WT, OP_INC, OP_P, OP_DHOLD, OP_D, OP_U,
      OP_PWM, OP_OUT
   } alu_op_type;

   // a step branches to itself while its hold condition is true
   typedef enum logic [1:0] {
      HOLD_NEVER, HOLD_REQ_IDLE, HOLD_RSP_FULL
   } hold_type;

   typedef logic [STEP_W-1:0] step_type;

   typedef struct packed {
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      alu_op_type op;
      hold_type   hold;
      step_type   next;
   } uword_type;

   // control from sequencer to datapath
   typedef struct packed {
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      alu_op_type op;
      logic       go;
   } ctrl_type;

   function automatic uword_type uw(input mul_a_type a, input mul_b_type b,
                                    input alu_op_type op, input hold_type h,
                                    input step_type nxt);
      return '{mul_a: a, mul_b: b, op: op, hold: h, next: nxt};
   endfunction

   // control program: at most one product per step, consumed in the following step
   function automatic uword_type ucode_rom(input step_type step);
      unique case (step)
         step_type'(0):  return uw(MA_NONE,   MB_TARGET, OP_LOAD,  HOLD_REQ_IDLE, step_type'(1));
         step_type'(1):  return uw(MA_WEIGHT, MB_TARGET, OP_DIFF,  HOLD_NEVER,    step_type'(2));
         step_type'(2):  return uw(MA_KI,     MB_ERR,    OP_WT,    HOLD_NEVER,    step_type'(3));
         step_type'(3):  return uw(MA_KP,     MB_WT,     OP_INC,   HOLD_NEVER,    step_type'(4));
         step_type'(4):  return uw(MA_POLE,   MB_DACC,   OP_P,     HOLD_NEVER,    step_type'(5));
         step_type'(5):  return uw(MA_GAIN,   MB_DY,     OP_DHOLD, HOLD_NEVER,    step_type'(6));
         step_type'(6):  return uw(MA_NONE,   MB_TARGET, OP_D,     HOLD_NEVER,    step_type'(7));
         step_type'(7):  return uw(MA_NONE,   MB_TARGET, OP_U,     HOLD_NEVER,    step_type'(8));
         step_type'(8):  return uw(MA_SPAN,   MB_U,      OP_NOP,   HOLD_NEVER,    step_type'(9));
         step_type'(9):  return uw(MA_NONE,   MB_TARGET, OP_PWM,   HOLD_NEVER,    step_type'(10));
         step_type'(10): return uw(MA_NONE,   MB_TARGET, OP_OUT,   HOLD_RSP_FULL, step_type'(0));
         default:        return uw(MA_NONE,   MB_TARGET, OP_NOP,   HOLD_NEVER,    step_type'(0));
      endcase
   endfunction

   // saturate a wide signed value to the data word
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      if (v[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){v[PROD_W-1]}}) begin
         return v[DATA_W-1:0];
      end
      return v[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
   endfunction

   // sign extend a data word to product width
   function automatic logic signed [PROD_W-1:0] sext(input logic signed [DATA_W-1:0] x);
      return PROD_W'(x);
   endfunction

endpackage

// ===== rtl/core/pidpwm_useq.sv =====
// pidpwm_useq: step counter and microcode table walk for the pid controller.
// Depends on pidpwm_pkg.
module pidpwm_useq import pidpwm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     rsp_full,
   output logic     req_tready,
   output ctrl_type ctrl
);

   step_type  step_ff, step_in;
   uword_type word;
   logic      stall;

   // fetch, hold check and next step
   always_comb begin
      word = ucode_rom(step_ff);
      unique case (word.hold)
         HOLD_NEVER:    stall = 1'b0;
         HOLD_REQ_IDLE: stall = !req_tvalid;
         HOLD_RSP_FULL: stall = rsp_full;
         default:       stall = 1'b0;
      endcase
      step_in    = stall ? step_ff : word.next;
      ctrl       = '{mul_a: word.mul_a, mul_b: word.mul_b, op: word.op, go: !stall};
      req_tready = (word.op == OP_LOAD);
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/core/pidpwm_dpath.sv =====
// pidpwm_dpath: control registers, loop state, shared multiplier, term
// arithmetic and output register of the pid controller. Depends on pidpwm_pkg.
module pidpwm_dpath import pidpwm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             ctrl,
   input  logic [REQ_W-1:0]     req_tdata,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [RSP_W-1:0]     rsp_tdata,
   output logic                 rsp_full
);

   // control registers
   logic signed [DATA_W-1:0] kp_ff, kp_in, wgt_ff, wgt_in, ki_ff, ki_in;
   logic signed [DATA_W-1:0] pole_ff, pole_in, gain_ff, gain_in;
   logic signed [DATA_W-1:0] max_ff, max_in, min_ff, min_in, ctr_ff, ctr_in;
   // loop state
   logic signed [DATA_W-1:0] integ_ff, integ_in, prev_ff, prev_in, dacc_ff, dacc_in;
   // working registers
   logic signed [DATA_W-1:0] y_ff, y_in, yd_ff, yd_in, err_ff, err_in, dy_ff, dy_in;
   logic signed [DATA_W-1:0] wt_ff, wt_in, p_ff, p_in, u_ff, u_in;
   logic signed [MUL_W-1:0]  span_ff, span_in;
   logic signed [PWM_W-1:0]  hold_ff, hold_in, pw_ff, pw_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   // output register
   logic signed [DATA_W-1:0] out_pwm_ff, out_pwm_in;
   clip_type                 out_clip_ff, out_clip_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] shifted, shifted_half;
   logic                     below_min, above_max, min_over_max;

   always_comb begin
      // multiplier operand selection
      unique case (ctrl.mul_a)
         MA_NONE:   mul_a = '0;
         MA_WEIGHT: mul_a = MUL_W'(wgt_ff);
         MA_KP:     mul_a = MUL_W'(kp_ff);
         MA_KI:     mul_a = MUL_W'(ki_ff);
         MA_POLE:   mul_a = MUL_W'(pole_ff);
         MA_GAIN:   mul_a = MUL_W'(gain_ff);
         MA_SPAN:   mul_a = span_ff;
         default:   mul_a = '0;
      endcase
      unique case (ctrl.mul_b)
         MB_TARGET: mul_b = MUL_W'(yd_ff);
         MB_WT:     mul_b = MUL_W'(wt_ff);
         MB_ERR:    mul_b = MUL_W'(err_ff);
         MB_DACC:   mul_b = MUL_W'(dacc_ff);
         MB_DY:     mul_b = MUL_W'(dy_ff);
         MB_U:      mul_b = MUL_W'(u_ff);
         default:   mul_b = '0;
      endcase

      // floored product scaling
      shifted      = prod_ff >>> FRAC_BITS;
      shifted_half = prod_ff >>> (FRAC_BITS + 1);

      // clamp compares, lower test first, max wins when min exceeds max
      below_min    = pw_ff < PWM_W'(min_ff);
      above_max    = pw_ff > PWM_W'(max_ff);
      min_over_max = min_ff > max_ff;

      kp_in = kp_ff;  wgt_in = wgt_ff;  ki_in = ki_ff;  pole_in = pole_ff;
      gain_in = gain_ff;  max_in = max_ff;  min_in = min_ff;  ctr_in = ctr_ff;
      integ_in = integ_ff;  prev_in = prev_ff;  dacc_in = dacc_ff;
      y_in = y_ff;  yd_in = yd_ff;  err_in = err_ff;  dy_in = dy_ff;
      wt_in = wt_ff;  p_in = p_ff;  u_in = u_ff;  span_in = span_ff;
      hold_in = hold_ff;  pw_in = pw_ff;  prod_in = prod_ff;
      out_pwm_in = out_pwm_ff;  out_clip_in = out_clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // shared multiplier
      if (ctrl.go && ctrl.mul_a != MA_NONE) begin
         prod_in = mul_a * mul_b;
      end

      // step operation
      if (ctrl.go) begin
         unique case (ctrl.op)
            OP_NOP: begin
            end
            OP_LOAD: begin
               y_in  = req_tdata[DATA_W-1:0];
               yd_in = req_tdata[REQ_W-1:DATA_W];
            end
            OP_DIFF: begin
               err_in  = sat32(sext(yd_ff) - sext(y_ff));
               dy_in   = sat32(sext(y_ff) - sext(prev_ff));
               span_in = MUL_W'(min_ff) - MUL_W'(max_ff);
            end
            OP_WT:    wt_in = sat32(sext(sat32(shifted)) - sext(y_ff));
            OP_INC:   integ_in = sat32(sext(integ_ff) + sext(sat32(shifted)));
            OP_P:     p_in = sat32(shifted);
            OP_DHOLD: hold_in = shifted[PWM_W-1:0];
            OP_D: begin
               dacc_in = sat32(PROD_W'(hold_ff) - shifted);
               prev_in = y_ff;
            end
            OP_U:     u_in = sat32(sext(p_ff) + sext(integ_ff) + sext(dacc_ff));
            OP_PWM:   pw_in = PWM_W'(ctr_ff) + signed'(shifted_half[PWM_W-1:0]);
            OP_OUT: begin
               rsp_valid_in = 1'b1;
               if (below_min) begin
                  out_pwm_in  = min_over_max ? max_ff : min_ff;
                  out_clip_in = min_over_max ? CLIP_MAX : CLIP_MIN;
               end else if (above_max) begin
                  out_pwm_in  = max_ff;
                  out_clip_in = CLIP_MAX;
               end else begin
                  out_pwm_in  = pw_ff[DATA_W-1:0];
                  out_clip_in = CLIP_NONE;
               end
            end
            default: begin
            end
         endcase
      end

      // register write, clears the loop state
      if (csr_valid) begin
         integ_in = '0;
         prev_in  = '0;
         dacc_in  = '0;
         unique case (csr_idx_type'(csr_index))
            REG_PROP_GAIN:  kp_in   = csr_data;
            REG_SP_WEIGHT:  wgt_in  = csr_data;
            REG_INTEG_GAIN: ki_in   = csr_data;
            REG_D_POLE:     pole_in = csr_data;
            REG_D_GAIN:     gain_in = csr_data;
            REG_PWM_MAX:    max_in  = csr_data;
            REG_PWM_MIN:    min_in  = csr_data;
            REG_PWM_CENTER: ctr_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   // control registers, loop state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= RST_PROP_GAIN;
         wgt_ff       <= RST_SP_WEIGHT;
         ki_ff        <= RST_INTEG_GAIN;
         pole_ff      <= RST_D_POLE;
         gain_ff      <= RST_D_GAIN;
         max_ff       <= RST_PWM_MAX;
         min_ff       <= RST_PWM_MIN;
         ctr_ff       <= RST_PWM_CENTER;
         integ_ff     <= '0;
         prev_ff      <= '0;
         dacc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kp_ff        <= kp_in;
         wgt_ff       <= wgt_in;
         ki_ff        <= ki_in;
         pole_ff      <= pole_in;
         gain_ff      <= gain_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         ctr_ff       <= ctr_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         dacc_ff      <= dacc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      y_ff        <= y_in;
      yd_ff       <= yd_in;
      err_ff      <= err_in;
      dy_ff       <= dy_in;
      wt_ff       <= wt_in;
      p_ff        <= p_in;
      u_ff        <= u_in;
      span_ff     <= span_in;
      hold_ff     <= hold_in;
      pw_ff       <= pw_in;
      prod_ff     <= prod_in;
      out_pwm_ff  <= out_pwm_in;
      out_clip_ff <= out_clip_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_full   = rsp_valid_ff && !rsp_tready;
   assign rsp_tdata  = {{(RSP_W-DATA_W-CLIP_W){1'b0}}, out_clip_ff, out_pwm_ff};

endmodule

// ===== rtl/core/pid_with_filtered_derivative_to_pwm.sv =====
// pid_with_filtered_derivative_to_pwm: top level of the pid controller with
// filtered derivative and pwm mapping. Depends on pidpwm_pkg, pidpwm_useq
// and pidpwm_dpath.
//
//   channel   direction  handshake               payload
//   req_      in         req_tvalid/req_tready   measured, target
//   rsp_      out        rsp_tvalid/rsp_tready   pwm_value, clip_side
//   csr_      in         csr_valid/csr_ready     csr_index, csr_data
//
// For each word the program issues six products through a single 33x33
// multiplier, at most one per step. A new word is taken only after the
// previous one has run through the final step of the program.
// The result register holds the last word while the next one is computed;
// the final step waits only while that register is still occupied.
// Reset loads the register defaults and clears the loop state; any register
// write also clears the loop state.
module pid_with_filtered_derivative_to_pwm import pidpwm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // measured [31:0], target [63:32]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // pwm_value [31:0], clip_side [33:32]
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   ctrl_type ctrl;
   logic     rsp_full;

   // register writes are always taken
   assign csr_ready = 1'b1;

   pidpwm_useq u_useq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_full   (rsp_full),
      .req_tready (req_tready),
      .ctrl       (ctrl)
   );

   pidpwm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_full   (rsp_full)
   );

endmodule

// ===== rtl/core/pidpwm_check.sv =====
// pidpwm_check: port level checks of the pid controller, bound to the top
// level. Depends on pidpwm_pkg and pid_with_filtered_derivative_to_pwm.
module pidpwm_check import pidpwm_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RSP_W-1:0]     rsp_tdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // one word in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again right after a word");

   // input side closes only after taking a word
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid))
      else $error("input ready dropped without a word");

   // a result shows up only at the end of a word's program
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while waiting for input");

endmodule

bind pid_with_filtered_derivative_to_pwm pidpwm_check u_check (.*);
